/* design/tst_pkg.sv */
// ----------------------------------------------------------------------------
// tst_pkg: shared types and constants
// Widths, command codes and step helpers for the series/tangent datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package tst_pkg;

  localparam int unsigned TERMS_DEF = 10;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned ANGLE_W   = 23;
  localparam int unsigned VALUE_W   = 32;

  localparam int unsigned SQ_W    = 2 * ANGLE_W;
  localparam int unsigned X2_W    = 29;
  localparam int unsigned T_W     = 36;
  localparam int unsigned SUM_W   = 41;
  localparam int unsigned P_W     = 66;
  localparam int unsigned Y_SH    = 24;
  localparam int unsigned Y_W     = 40;
  localparam int unsigned DIG_W   = 13;
  localparam int unsigned STEP_W  = 11;
  localparam int unsigned V_W     = STEP_W + DIG_W;
  localparam int unsigned MAG_W   = 26;

  localparam int unsigned NUM_W   = 66;
  localparam int unsigned DEN_W   = 41;
  localparam int unsigned QUO_W   = 32;

  localparam int unsigned LANE_LAT  = 8;
  localparam int unsigned QDIV_LAT  = QUO_W + 2;
  localparam int unsigned FIXED_LAT = 6 + QDIV_LAT;

  localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef enum logic [CMD_W-1:0] {
    CMD_SIN  = 2'd0,
    CMD_COS  = 2'd1,
    CMD_TAN  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic              neg;
    logic [X2_W-1:0]   x2;
  } tag_t;

  typedef struct packed {
    cmd_t                cmd;
    logic [VALUE_W-1:0]  val;
  } side_t;

  // factorial step of term n: 2n(2n+1) for sine, 2n(2n-1) for cosine
  function automatic int unsigned term_step(bit odd, int unsigned n);
    int unsigned m;
    m = 2 * n;
    return odd ? m * (m + 1) : m * (m - 1);
  endfunction

  function automatic int unsigned total_lat(int unsigned terms);
    return terms * LANE_LAT + FIXED_LAT;
  endfunction

endpackage
`default_nettype wire

/* design/tst_lane.sv */
// ----------------------------------------------------------------------------
// tst_lane: one series term
// t_out = round(t_in * x2 / (STEP << 24)), sum_out = sum_in -/+ t_out.
// Constant divide in three digits (a 14-bit top digit, two 13-bit digits) by exact reciprocal multiply.
// ----------------------------------------------------------------------------
`default_nettype none
module tst_lane #(
  parameter int unsigned STEP = 2,
  parameter bit          SUB  = 1'b1
) (
  input  logic                               clk,
  input  logic [tst_pkg::X2_W-1:0]           x2,
  input  logic [tst_pkg::T_W-1:0]            t_in,
  input  logic signed [tst_pkg::SUM_W-1:0]   sum_in,
  output logic [tst_pkg::T_W-1:0]            t_out,
  output logic signed [tst_pkg::SUM_W-1:0]   sum_out
);
  import tst_pkg::*;

  localparam int unsigned HALF  = T_W / 2;
  localparam int unsigned PP_W  = HALF + X2_W;
  localparam int unsigned YH_W  = Y_W - 2 * DIG_W;
  localparam int unsigned PR_W  = V_W + MAG_W;
  localparam int unsigned SH    = DIG_W + 2 * $clog2(STEP);
  localparam longint unsigned MAG64 =
    ((64'd1 << SH) + 64'(STEP) - 64'd1) / 64'(STEP);
  localparam logic [MAG_W-1:0] MAG    = MAG_W'(MAG64);
  localparam logic [V_W-1:0]   STEP_V = V_W'(STEP);
  localparam logic [P_W-1:0]   RND    = P_W'(STEP) << (Y_SH - 1);

  logic [PP_W-1:0]           pl, ph;
  logic [Y_W-1:0]            y;
  logic [YH_W-1:0]           yh3;
  logic [2*DIG_W-1:0]        ylo3, ylo4;
  logic [DIG_W-1:0]          ylo5, ylo6;
  logic [YH_W-1:0]           q0, q0_4, q0_5, q0_6, q0_7;
  logic [DIG_W-1:0]          q1, q1_6, q1_7, q2;
  logic [STEP_W-1:0]         r0, r1;
  logic [V_W-1:0]            v1;
  logic signed [SUM_W-1:0]   sum1, sum2, sum3, sum4, sum5, sum6, sum7;

  logic [P_W-1:0]            p_next;
  logic [PR_W-1:0]           prod0, prod1, prod2;
  logic [V_W-1:0]            v1_next, v2_next;
  logic [Y_W-1:0]            tq;
  logic signed [SUM_W-1:0]   tt;

  always_comb begin
    p_next  = (P_W'(ph) << HALF) + P_W'(pl) + RND;
    prod0   = PR_W'(y[Y_W-1:2*DIG_W]) * PR_W'(MAG);
    v1_next = {r0, ylo4[2*DIG_W-1:DIG_W]};
    prod1   = PR_W'(v1_next) * PR_W'(MAG);
    v2_next = {r1, ylo6};
    prod2   = PR_W'(v2_next) * PR_W'(MAG);
    tq      = {q0_7, q1_7, q2};
    tt      = $signed(SUM_W'(tq[T_W-1:0]));
  end

  always_ff @(posedge clk) begin
    pl   <= PP_W'(t_in[HALF-1:0]) * PP_W'(x2);
    ph   <= PP_W'(t_in[T_W-1:HALF]) * PP_W'(x2);
    sum1 <= sum_in;

    y    <= p_next[Y_SH+Y_W-1:Y_SH];
    sum2 <= sum1;

    q0   <= YH_W'(prod0 >> SH);
    yh3  <= y[Y_W-1:2*DIG_W];
    ylo3 <= y[2*DIG_W-1:0];
    sum3 <= sum2;

    r0   <= STEP_W'(V_W'(yh3) - V_W'(q0) * STEP_V);
    q0_4 <= q0;
    ylo4 <= ylo3;
    sum4 <= sum3;

    q1   <= DIG_W'(prod1 >> SH);
    v1   <= v1_next;
    q0_5 <= q0_4;
    ylo5 <= ylo4[DIG_W-1:0];
    sum5 <= sum4;

    r1   <= STEP_W'(v1 - V_W'(q1) * STEP_V);
    q1_6 <= q1;
    q0_6 <= q0_5;
    ylo6 <= ylo5;
    sum6 <= sum5;

    q2   <= DIG_W'(prod2 >> SH);
    q1_7 <= q1_6;
    q0_7 <= q0_6;
    sum7 <= sum6;

    t_out   <= tq[T_W-1:0];
    sum_out <= SUB ? sum7 - tt : sum7 + tt;
  end

endmodule
`default_nettype wire

/* design/tst_qdiv.sv */
// ----------------------------------------------------------------------------
// tst_qdiv: pipelined restoring divider for tangent
// One quotient bit per stage, saturation to the signed 32-bit range.
// ----------------------------------------------------------------------------
`default_nettype none
module tst_qdiv (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic [tst_pkg::NUM_W-1:0]       num,
  input  logic [tst_pkg::DEN_W-1:0]       den,
  input  logic                            neg,
  input  tst_pkg::side_t                  in_side,
  output logic                            out_valid,
  output logic [tst_pkg::VALUE_W-1:0]     quo,
  output logic                            ovf,
  output tst_pkg::side_t                  out_side
);
  import tst_pkg::*;

  localparam int unsigned HI_W = NUM_W - QUO_W;

  logic [QUO_W:0]   vld;
  logic [DEN_W-1:0] rem   [0:QUO_W];
  logic [DEN_W-1:0] dv    [0:QUO_W];
  logic [QUO_W-1:0] lo    [0:QUO_W];
  logic [QUO_W-1:0] qb    [0:QUO_W];
  logic             sgn   [0:QUO_W];
  logic             big   [0:QUO_W];
  side_t            sd    [0:QUO_W];

  logic [HI_W-1:0]  hi;
  logic [QUO_W:0]   lim;
  logic             over;

  assign hi = num[NUM_W-1:QUO_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[QUO_W-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    rem[0] <= DEN_W'(hi);
    big[0] <= DEN_W'(hi) >= den;
    dv[0]  <= den;
    lo[0]  <= num[QUO_W-1:0];
    qb[0]  <= '0;
    sgn[0] <= neg;
    sd[0]  <= in_side;
  end

  for (genvar i = 0; i < QUO_W; i++) begin : g_step
    logic [DEN_W:0] rs;
    logic           ge;
    always_comb begin
      rs = {rem[i], lo[i][QUO_W-1-i]};
      ge = rs >= {1'b0, dv[i]};
    end
    always_ff @(posedge clk) begin
      rem[i+1] <= ge ? DEN_W'(rs - {1'b0, dv[i]}) : DEN_W'(rs);
      qb[i+1]  <= qb[i] | (QUO_W'(ge) << (QUO_W - 1 - i));
      dv[i+1]  <= dv[i];
      lo[i+1]  <= lo[i];
      sgn[i+1] <= sgn[i];
      big[i+1] <= big[i];
      sd[i+1]  <= sd[i];
    end
  end

  always_comb begin
    lim  = sgn[QUO_W] ? {2'b01, {(QUO_W-1){1'b0}}} : {2'b00, {(QUO_W-1){1'b1}}};
    over = big[QUO_W] || ({1'b0, qb[QUO_W]} > lim);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    ovf      <= over;
    out_side <= sd[QUO_W];
    if (over) begin
      quo <= sgn[QUO_W] ? VAL_MIN : VAL_MAX;
    end else begin
      quo <= sgn[QUO_W] ? (~qb[QUO_W] + 1'b1) : qb[QUO_W];
    end
  end

endmodule
`default_nettype wire

/* design/sine_cosine_tangent_series.sv */
// ----------------------------------------------------------------------------
// sine_cosine_tangent_series: Taylor series sine, cosine and tangent
// Throughput: one request per cycle; busy is high only during reset.
// Datapath: the series term pipeline (8 stages each) and the divider (32 quotient-bit stages).
// Synchronous reset clears all valid bits; outside reset no result is lost once accepted.
// ----------------------------------------------------------------------------
`default_nettype none
module sine_cosine_tangent_series #(
  parameter int unsigned SERIES_TERMS = tst_pkg::TERMS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [tst_pkg::CMD_W-1:0]           command,
  input  logic signed [tst_pkg::ANGLE_W-1:0]  angle,
  output logic                                busy,
  output logic                                done,
  output logic signed [tst_pkg::VALUE_W-1:0]  value,
  output logic                                overflow
);
  import tst_pkg::*;

  localparam int unsigned SER_LAT = SERIES_TERMS * LANE_LAT;

  logic                    v0, v1, f1v, f2v;
  cmd_t                    cmd0, cmd1;
  logic                    neg0, neg1;
  logic [ANGLE_W-1:0]      ux0, ux1;
  logic [SQ_W-1:0]         sq1;

  logic [SER_LAT:0]        vld;
  tag_t                    tagd [0:SER_LAT];

  logic [T_W-1:0]          t_s   [0:SERIES_TERMS];
  logic [T_W-1:0]          t_c   [0:SERIES_TERMS];
  logic signed [SUM_W-1:0] sum_s [0:SERIES_TERMS];
  logic signed [SUM_W-1:0] sum_c [0:SERIES_TERMS];

  logic signed [SUM_W-1:0] ssig, csig;
  cmd_t                    cmd_f1;

  logic [NUM_W-1:0]        num;
  logic [DEN_W-1:0]        den;
  logic                    qneg;
  side_t                   side_f2;

  logic                    dvalid;
  logic [VALUE_W-1:0]      dquo;
  logic                    dovf;
  side_t                   dside;

  logic [ANGLE_W-1:0]      ux_next;
  logic [SQ_W-1:0]         sq_rnd;
  logic signed [SUM_W-1:0] s_fin, sel, rnd;
  logic [DEN_W-1:0]        as_next, ac_next;
  logic [VALUE_W-1:0]      sc_next;

  assign busy    = rst;
  assign ux_next = angle[ANGLE_W-1] ? ~angle + 1'b1 : angle;
  assign sq_rnd  = sq1 + SQ_W'(16'h8000);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0  <= 1'b0;
      v1  <= 1'b0;
      vld <= '0;
      f1v <= 1'b0;
      f2v <= 1'b0;
    end else begin
      v0  <= start && !busy;
      v1  <= v0;
      vld <= {vld[SER_LAT-1:0], v1};
      f1v <= vld[SER_LAT];
      f2v <= f1v;
    end
  end

  always_ff @(posedge clk) begin
    cmd0 <= cmd_t'(command);
    neg0 <= angle[ANGLE_W-1];
    ux0  <= ux_next;

    cmd1 <= cmd0;
    neg1 <= neg0;
    ux1  <= ux0;
    sq1  <= SQ_W'(ux0) * SQ_W'(ux0);

    tagd[0].cmd <= cmd1;
    tagd[0].neg <= neg1;
    tagd[0].x2  <= sq_rnd[16+X2_W-1:16];
    t_s[0]      <= T_W'(ux1) << 12;
    sum_s[0]    <= $signed(SUM_W'(ux1) << 12);
    t_c[0]      <= T_W'(1) << 32;
    sum_c[0]    <= $signed(SUM_W'(1) << 32);

    for (int i = 0; i < SER_LAT; i++) begin
      tagd[i+1] <= tagd[i];
    end
  end

  for (genvar k = 0; k < SERIES_TERMS; k++) begin : g_term
    localparam int unsigned SIN_STEP = term_step(1'b1, k + 1);
    localparam int unsigned COS_STEP = term_step(1'b0, k + 1);
    localparam bit          SUB      = (k % 2) == 0;

    tst_lane #(.STEP(SIN_STEP), .SUB(SUB)) u_sin (
      .clk     (clk),
      .x2      (tagd[k*LANE_LAT].x2),
      .t_in    (t_s[k]),
      .sum_in  (sum_s[k]),
      .t_out   (t_s[k+1]),
      .sum_out (sum_s[k+1])
    );

    tst_lane #(.STEP(COS_STEP), .SUB(SUB)) u_cos (
      .clk     (clk),
      .x2      (tagd[k*LANE_LAT].x2),
      .t_in    (t_c[k]),
      .sum_in  (sum_c[k]),
      .t_out   (t_c[k+1]),
      .sum_out (sum_c[k+1])
    );
  end

  assign s_fin = sum_s[SERIES_TERMS];

  always_ff @(posedge clk) begin
    ssig   <= tagd[SER_LAT].neg ? -s_fin : s_fin;
    csig   <= sum_c[SERIES_TERMS];
    cmd_f1 <= tagd[SER_LAT].cmd;
  end

  always_comb begin
    sel     = (cmd_f1 == CMD_SIN) ? ssig : csig;
    rnd     = (sel + SUM_W'(128)) >>> 8;
    as_next = ssig[SUM_W-1] ? DEN_W'(-ssig) : DEN_W'(ssig);
    ac_next = csig[SUM_W-1] ? DEN_W'(-csig) : DEN_W'(csig);
    if (rnd > SUM_W'(VAL_MAX)) begin
      sc_next = VAL_MAX;
    end else if (rnd < SUM_W'(VAL_MIN)) begin
      sc_next = VAL_MIN;
    end else begin
      sc_next = rnd[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    num         <= (NUM_W'(as_next) << Y_SH) + NUM_W'(ac_next >> 1);
    den         <= ac_next;
    qneg        <= ssig[SUM_W-1] ^ csig[SUM_W-1];
    side_f2.cmd <= cmd_f1;
    side_f2.val <= sc_next;
  end

  tst_qdiv u_qdiv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f2v),
    .num       (num),
    .den       (den),
    .neg       (qneg),
    .in_side   (side_f2),
    .out_valid (dvalid),
    .quo       (dquo),
    .ovf       (dovf),
    .out_side  (dside)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dvalid;
    end
  end

  always_ff @(posedge clk) begin
    case (dside.cmd)
      CMD_SIN, CMD_COS: begin
        value    <= dside.val;
        overflow <= 1'b0;
      end
      CMD_TAN: begin
        value    <= dquo;
        overflow <= dovf;
      end
      default: begin
        value    <= '0;
        overflow <= 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

/* design/tst_chk.sv */
// ----------------------------------------------------------------------------
// tst_chk: port-level checker
// Fixed latency and command-dependent result checks, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module tst_chk #(
  parameter int unsigned SERIES_TERMS = tst_pkg::TERMS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                busy,
  input  logic [tst_pkg::CMD_W-1:0]           command,
  input  logic                                done,
  input  logic signed [tst_pkg::VALUE_W-1:0]  value,
  input  logic                                overflow
);
  import tst_pkg::*;

  localparam int unsigned LAT   = total_lat(SERIES_TERMS);
  localparam int unsigned CNT_W = $clog2(LAT + 1);

  logic [CNT_W-1:0] cnt;
  logic             warm;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cnt != CNT_W'(LAT)) begin
      cnt <= cnt + 1'b1;
    end
  end

  assign warm = (cnt == CNT_W'(LAT));

  a_busy_reset: assert property (@(posedge clk) !rst |-> !busy)
    else $error("busy outside reset");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    warm |-> (done == $past(start && !busy, LAT)))
    else $error("request/done latency mismatch");

  a_no_ovf: assert property (@(posedge clk) disable iff (rst)
    (warm && done && $past(command, LAT) != CMD_TAN) |-> !overflow)
    else $error("overflow on non-tangent request");

  a_unused_cmd: assert property (@(posedge clk) disable iff (rst)
    (warm && done && $past(command, LAT) == CMD_NONE) |-> (value == '0))
    else $error("unused command gave nonzero value");

endmodule

bind sine_cosine_tangent_series tst_chk #(.SERIES_TERMS(SERIES_TERMS)) u_chk (.*);
`default_nettype wire
